[rtl/core/xsf_pkg.sv]
// ----------------------------------------------------------------------------
// xsf_pkg
// Beat types, mode codes and sprite constants for the XOR sprite
// framebuffer core.
// ----------------------------------------------------------------------------
package xsf_pkg;

  // mode codes
  localparam logic [1:0] MODE_DRAW  = 2'd0;
  localparam logic [1:0] MODE_SET   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  // one sprite row is eight pixels, bit 7 leftmost
  localparam int unsigned SPRITE_SPAN     = 8;
  localparam logic [7:0]  SPRITE_LEFT_BIT = 8'h80;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [3:0] row_index;
    logic [7:0] sprite_bits;
    logic       last_row;
  } in_beat_t;

  typedef struct packed {
    logic collision;
    logic pixel_value;
  } out_beat_t;

endpackage

[rtl/core/xor_sprite_framebuffer_core.sv]
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_core
// Sequencing: an accepted beat has its row read at acceptance; the
//   read-modify-write state then modifies and writes back the row and
//   loads the result beat; a result held by the receiver stalls it.
// Intake: a new beat is accepted only in idle, so each beat, in every
//   mode, finishes the single read-modify-write of one row word first.
// Reset: clears control, the collision flag and the row valid bits; the
//   screen reads blank immediately, with no clearing pass.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer_core #(
  parameter int unsigned SCREEN_WIDTH  = 64,
  parameter int unsigned SCREEN_HEIGHT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  xsf_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output xsf_pkg::out_beat_t out_data
);

  import xsf_pkg::*;

  localparam int unsigned CW = $clog2(SCREEN_WIDTH);
  localparam int unsigned RW = $clog2(SCREEN_HEIGHT);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RMW  = 1'b1;

  logic                    state;
  logic                    state_next;
  in_beat_t                beat_q;
  logic [CW-1:0]           col_q;
  logic [RW-1:0]           row_q;
  logic                    sticky;

  logic                    accept;
  logic                    finish;
  logic [3:0]              row_offset;
  logic [CW-1:0]           col_w;
  logic [RW-1:0]           row_w;

  logic                    mem_clr;
  logic                    mem_wr;
  logic                    mem_rd;
  logic [SCREEN_WIDTH-1:0] old_row;
  logic [SCREEN_WIDTH-1:0] new_row;
  logic [SCREEN_WIDTH-1:0] toggle;
  logic [CW:0]             col_k;
  logic                    hit;
  out_beat_t               result;
  logic                    sticky_next;

  // handshake and sequencing
  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state == ST_RMW) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_RMW;
      ST_RMW:  if (finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // coordinate wrap; row offset only applies to sprite rows
  assign row_offset = (in_data.mode == MODE_DRAW) ? in_data.row_index : 4'd0;

  xsf_wrap #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .CW           (CW),
    .RW           (RW)
  ) u_wrap (
    .x_pos     (in_data.x_pos),
    .y_pos     (in_data.y_pos),
    .row_offset(row_offset),
    .col       (col_w),
    .row       (row_w)
  );

  // capture the beat alongside the row read
  always_ff @(posedge clk) begin
    if (accept) begin
      beat_q <= in_data;
      col_q  <= col_w;
      row_q  <= row_w;
    end
  end

  assign mem_rd  = accept;
  assign mem_wr  = finish && ((beat_q.mode == MODE_DRAW) || (beat_q.mode == MODE_SET));
  assign mem_clr = finish && (beat_q.mode == MODE_CLEAR);

  xsf_mem #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .RW           (RW)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .clr_all(mem_clr),
    .wr_en  (mem_wr),
    .wr_addr(row_q),
    .wr_data(new_row),
    .rd_en  (mem_rd),
    .rd_addr(row_w),
    .rd_data(old_row)
  );

  // sprite toggle mask: eight columns from the origin, wrapping right edge
  always_comb begin
    toggle = '0;
    col_k  = '0;
    for (int k = 0; k < SPRITE_SPAN; k++) begin
      col_k = {1'b0, col_q} + (CW+1)'(k);
      if (col_k >= (CW+1)'(SCREEN_WIDTH)) begin
        col_k = col_k - (CW+1)'(SCREEN_WIDTH);
      end
      if ((beat_q.sprite_bits & (SPRITE_LEFT_BIT >> k)) != 8'd0) begin
        toggle = toggle | (SCREEN_WIDTH'(1) << col_k[CW-1:0]);
      end
    end
  end

  assign hit = |(old_row & toggle);

  // modify the row and form the result
  always_comb begin
    new_row            = old_row;
    result.collision   = 1'b0;
    result.pixel_value = 1'b0;
    sticky_next        = sticky;
    case (beat_q.mode)
      MODE_DRAW: begin
        new_row     = old_row ^ toggle;
        sticky_next = sticky | hit;
        if (beat_q.last_row) begin
          result.collision = sticky_next;
          sticky_next      = 1'b0;
        end
      end
      MODE_SET:  new_row = old_row | (SCREEN_WIDTH'(1) << col_q);
      MODE_READ: result.pixel_value = old_row[col_q];
      default:   new_row = '0;
    endcase
  end

  // collision flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sticky <= 1'b0;
    end else if (finish) begin
      sticky <= sticky_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= result;
    end
  end

  // checks
  a_accept_to_rmw: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_RMW))
    else $error("accepted beat did not enter read-modify-write");

  a_sticky_cleared: assert property (@(posedge clk) disable iff (rst)
    (finish && (beat_q.mode == MODE_DRAW) && beat_q.last_row) |=> !sticky)
    else $error("collision flag not cleared after last sprite row");

  a_pixel_only_on_read: assert property (@(posedge clk) disable iff (rst)
    (finish && (beat_q.mode != MODE_READ)) |=> !out_data.pixel_value)
    else $error("pixel value set on a non-read result");

  a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (rst)
    !(mem_rd && (mem_wr || mem_clr)))
    else $error("row read overlaps a row write or clear");

endmodule

[rtl/core/xsf_wrap.sv]
// ----------------------------------------------------------------------------
// xsf_wrap
// Wraps a pixel column and a row (origin plus row offset) onto the screen.
// Restoring compare-and-subtract against shifted copies of the screen size.
// ----------------------------------------------------------------------------
module xsf_wrap #(
  parameter int unsigned SCREEN_WIDTH  = 64,
  parameter int unsigned SCREEN_HEIGHT = 32,
  parameter int unsigned CW            = 6,
  parameter int unsigned RW            = 5
) (
  input  logic [7:0]    x_pos,
  input  logic [7:0]    y_pos,
  input  logic [3:0]    row_offset,
  output logic [CW-1:0] col,
  output logic [RW-1:0] row
);

  localparam int unsigned VW    = 13;
  localparam int unsigned STEPS = 7;

  logic [VW-1:0] col_rem;
  logic [VW-1:0] row_rem;

  // column: x < 256 and width >= 8, so subtracting width * 2^k for
  // k = 6..0 always leaves a value below width
  always_comb begin
    col_rem = {5'b0, x_pos};
    for (int k = STEPS - 1; k >= 0; k--) begin
      if (col_rem >= (VW'(SCREEN_WIDTH) << k)) begin
        col_rem = col_rem - (VW'(SCREEN_WIDTH) << k);
      end
    end
  end

  // row: origin plus offset stays below 271
  always_comb begin
    row_rem = {5'b0, y_pos} + {9'b0, row_offset};
    for (int k = STEPS - 1; k >= 0; k--) begin
      if (row_rem >= (VW'(SCREEN_HEIGHT) << k)) begin
        row_rem = row_rem - (VW'(SCREEN_HEIGHT) << k);
      end
    end
  end

  assign col = col_rem[CW-1:0];
  assign row = row_rem[RW-1:0];

endmodule

[rtl/core/xsf_mem.sv]
// ----------------------------------------------------------------------------
// xsf_mem
// Row store: one word per screen row, one write and one registered read
// per cycle. A valid bit per row makes unwritten rows read as blank, so
// reset and a full clear take effect at once.
// ----------------------------------------------------------------------------
module xsf_mem #(
  parameter int unsigned SCREEN_WIDTH  = 64,
  parameter int unsigned SCREEN_HEIGHT = 32,
  parameter int unsigned RW            = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clr_all,
  input  logic                    wr_en,
  input  logic [RW-1:0]           wr_addr,
  input  logic [SCREEN_WIDTH-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [RW-1:0]           rd_addr,
  output logic [SCREEN_WIDTH-1:0] rd_data
);

  logic [SCREEN_WIDTH-1:0]  mem [SCREEN_HEIGHT];
  logic [SCREEN_HEIGHT-1:0] row_valid;
  logic [SCREEN_WIDTH-1:0]  rd_word;
  logic                     rd_hit;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // per-row valid bits
  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hit <= 1'b0;
    end else if (rd_en) begin
      rd_hit <= row_valid[rd_addr];
    end
  end

  assign rd_data = rd_hit ? rd_word : '0;

endmodule
